// ===== hdl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Opcodes and the transaction record passed from front end to back end.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_MAC = 3'd3;
    localparam logic [2:0] CMD_NEG = 3'd4;
    localparam logic [2:0] CMD_POW = 3'd5;
    localparam logic [2:0] CMD_DIV = 3'd6;

    // Full width of the operand fields.
    localparam int FIELD_BITS = 32;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] c;
        logic [FIELD_BITS-1:0] d;
    } item_t;

endpackage

// ===== hdl/mau_fifo.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit queue
// Small two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mau_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  mau_pkg::item_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output mau_pkg::item_t rd_data
);
    mau_pkg::item_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       wr_en, rd_en;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (wr_en) begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule

// ===== hdl/mau_front.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit front end
// Accepts transactions, masks operands to the word width and queues them.
// ----------------------------------------------------------------------------
module mau_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [2:0]                           s_cmd,
    input  logic [mau_pkg::FIELD_BITS-1:0]       s_operand_a,
    input  logic [mau_pkg::FIELD_BITS-1:0]       s_operand_b,
    input  logic [mau_pkg::FIELD_BITS-1:0]       s_operand_c,
    input  logic [mau_pkg::FIELD_BITS-1:0]       s_operand_d,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output mau_pkg::item_t                       q_data
);
    localparam logic [mau_pkg::FIELD_BITS-1:0] MASK =
        {mau_pkg::FIELD_BITS{1'b1}} >> (mau_pkg::FIELD_BITS - WORD_BITS);

    mau_pkg::item_t item;

    always_comb begin
        item.cmd = s_cmd;
        item.a   = s_operand_a & MASK;
        item.b   = s_operand_b & MASK;
        item.c   = s_operand_c & MASK;
        item.d   = s_operand_d & MASK;
    end

    mau_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );
endmodule

// ===== hdl/mau_back.sv =====
// ----------------------------------------------------------------------------
// Modular arithmetic unit back end
// Sequencer with a shift-subtract reducer and a shift-add modular multiplier.
// ----------------------------------------------------------------------------
module mau_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [WORD_BITS-1:0]    modulus,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  mau_pkg::item_t          q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [mau_pkg::FIELD_BITS-1:0] m_result,
    output logic                    m_div_by_zero
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RED   = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_POW   = 4'd4;
    localparam logic [3:0] ST_EUC   = 4'd5;
    localparam logic [3:0] ST_DONE  = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;
    localparam logic [3:0] ST_EUCD  = 4'd8;

    // Step codes for what follows a multiply.
    localparam logic [2:0] NX_DONE   = 3'd0;
    localparam logic [2:0] NX_MAC2   = 3'd1;
    localparam logic [2:0] NX_MAC3   = 3'd2;
    localparam logic [2:0] NX_POWACC = 3'd3;
    localparam logic [2:0] NX_POWSQ  = 3'd4;

    logic [3:0]   state_reg;
    logic [2:0]   cmd_reg;
    logic [W-1:0] m_reg;
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [1:0]   ridx_reg;
    logic [W:0]   rem_reg;
    logic [W-1:0] rsrc_reg;
    logic [CW-1:0] cnt_reg;
    // Multiplier.
    logic [W-1:0] mx_reg, my_reg, macc_reg;
    logic [2:0]   nx_reg;
    // Pow.
    logic [W-1:0] acc_reg, sq_reg;
    // Euclid: r0,r1 remainders, t0,t1 coefficients mod m, q quotient.
    logic [W-1:0] r0_reg, r1_reg, t0_reg, t1_reg, q_reg;
    logic [W:0]   er_reg;
    logic [W-1:0] res_reg;
    logic         flag_reg;

    logic [W:0] rem_sh, rem_sub;
    logic [W:0] dbl, dbl_red, addv, addv_red;
    logic [W:0] er_sh, er_sub;

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign m_result = mau_pkg::FIELD_BITS'(res_reg);
    assign m_div_by_zero = flag_reg;

    // Restoring reduction, one bit a cycle.
    assign rem_sh  = {rem_reg[W-1:0], rsrc_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, m_reg};

    // Multiplier step: macc = 2*macc + (bit ? mx : 0), each reduced.
    assign dbl      = {macc_reg, 1'b0};
    assign dbl_red  = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
    assign addv     = dbl_red + (my_reg[W-1] ? {1'b0, mx_reg} : '0);
    assign addv_red = (addv >= {1'b0, m_reg}) ? addv - {1'b0, m_reg} : addv;

    // Euclid division r0 / r1, restoring, quotient into q.
    assign er_sh  = {er_reg[W-1:0], r0_reg[W-1]};
    assign er_sub = er_sh - {1'b0, r1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flag_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg  <= q_data.cmd;
                        m_reg    <= modulus;
                        a_reg    <= q_data.a[W-1:0];
                        b_reg    <= q_data.b[W-1:0];
                        c_reg    <= q_data.c[W-1:0];
                        d_reg    <= q_data.d[W-1:0];
                        e_reg    <= q_data.b[W-1:0];
                        ridx_reg <= 2'd0;
                        rem_reg  <= '0;
                        rsrc_reg <= q_data.a[W-1:0];
                        cnt_reg  <= CW'(W);
                        res_reg  <= '0;
                        flag_reg <= 1'b0;
                        if (modulus < W'(2) || q_data.cmd > mau_pkg::CMD_DIV) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    if (rem_sub[W]) begin
                        rem_reg <= rem_sh;
                    end else begin
                        rem_reg <= rem_sub;
                    end
                    rsrc_reg <= {rsrc_reg[W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        case (ridx_reg)
                            2'd0: begin
                                a_reg    <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                                rsrc_reg <= b_reg;
                            end
                            2'd1: begin
                                b_reg    <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                                rsrc_reg <= c_reg;
                            end
                            2'd2: begin
                                c_reg    <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                                rsrc_reg <= d_reg;
                            end
                            default: begin
                                d_reg <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                            end
                        endcase
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(W);
                        ridx_reg <= ridx_reg + 2'd1;
                        if (ridx_reg == 2'd3) begin
                            state_reg <= ST_DISP;
                        end
                    end
                end
                ST_DISP: begin
                    cnt_reg   <= CW'(W);
                    macc_reg  <= '0;
                    state_reg <= ST_DONE;
                    case (cmd_reg)
                        mau_pkg::CMD_ADD: begin
                            res_reg <= ({1'b0, a_reg} + {1'b0, b_reg} >= {1'b0, m_reg})
                                ? W'({1'b0, a_reg} + {1'b0, b_reg} - {1'b0, m_reg})
                                : a_reg + b_reg;
                            state_reg <= ST_OUT;
                        end
                        mau_pkg::CMD_SUB: begin
                            res_reg <= (a_reg >= b_reg) ? a_reg - b_reg : m_reg - b_reg + a_reg;
                            state_reg <= ST_OUT;
                        end
                        mau_pkg::CMD_NEG: begin
                            res_reg <= (a_reg == '0) ? '0 : m_reg - a_reg;
                            state_reg <= ST_OUT;
                        end
                        mau_pkg::CMD_MUL: begin
                            mx_reg <= a_reg; my_reg <= b_reg; nx_reg <= NX_DONE;
                            state_reg <= ST_MUL;
                        end
                        mau_pkg::CMD_MAC: begin
                            mx_reg <= b_reg; my_reg <= c_reg; nx_reg <= NX_MAC2;
                            state_reg <= ST_MUL;
                        end
                        mau_pkg::CMD_POW: begin
                            acc_reg <= W'(1);
                            sq_reg  <= a_reg;
                            state_reg <= ST_POW;
                        end
                        default: begin
                            if (b_reg == '0) begin
                                flag_reg  <= 1'b1;
                                state_reg <= ST_OUT;
                            end else begin
                                r0_reg <= m_reg; r1_reg <= b_reg;
                                t0_reg <= '0;    t1_reg <= W'(1);
                                er_reg <= '0;    q_reg  <= '0;
                                state_reg <= ST_EUC;
                            end
                        end
                    endcase
                end
                ST_MUL: begin
                    macc_reg <= addv_red[W-1:0];
                    my_reg   <= {my_reg[W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        cnt_reg  <= CW'(W);
                        macc_reg <= '0;
                        case (nx_reg)
                            NX_MAC2: begin
                                mx_reg <= addv_red[W-1:0]; my_reg <= d_reg; nx_reg <= NX_MAC3;
                            end
                            NX_MAC3: begin
                                res_reg <= ({1'b0, a_reg} + addv_red >= {1'b0, m_reg})
                                    ? W'({1'b0, a_reg} + addv_red - {1'b0, m_reg})
                                    : W'({1'b0, a_reg} + addv_red);
                                state_reg <= ST_OUT;
                            end
                            NX_POWACC: begin
                                acc_reg <= addv_red[W-1:0];
                                mx_reg <= sq_reg; my_reg <= sq_reg; nx_reg <= NX_POWSQ;
                            end
                            NX_POWSQ: begin
                                sq_reg <= addv_red[W-1:0];
                                e_reg  <= e_reg >> 1;
                                state_reg <= ST_POW;
                            end
                            default: begin
                                res_reg   <= addv_red[W-1:0];
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_POW: begin
                    cnt_reg <= CW'(W);
                    if (e_reg == '0) begin
                        res_reg   <= acc_reg;
                        state_reg <= ST_OUT;
                    end else if (e_reg[0]) begin
                        mx_reg <= acc_reg; my_reg <= sq_reg; nx_reg <= NX_POWACC;
                        state_reg <= ST_MUL;
                    end else begin
                        mx_reg <= sq_reg; my_reg <= sq_reg; nx_reg <= NX_POWSQ;
                        state_reg <= ST_MUL;
                    end
                end
                ST_EUC: begin
                    // One quotient bit per cycle of r0 / r1.
                    if (er_sub[W]) begin
                        er_reg <= er_sh;
                    end else begin
                        er_reg <= er_sub;
                    end
                    q_reg   <= {q_reg[W-2:0], ~er_sub[W]};
                    r0_reg  <= {r0_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        // r0 now holds shifted-out zeros; remainder is in er.
                        r0_reg <= r1_reg;
                        r1_reg <= er_sub[W] ? er_sh[W-1:0] : er_sub[W-1:0];
                        q_reg  <= {q_reg[W-2:0], ~er_sub[W]};
                        // t update: tn = t0 - q*t1 (mod m) via the multiplier.
                        mx_reg <= t1_reg;
                        my_reg <= {q_reg[W-2:0], ~er_sub[W]};
                        macc_reg <= '0;
                        cnt_reg  <= CW'(W);
                        state_reg <= ST_EUCD;
                    end
                end
                ST_EUCD: begin
                    // q*t1 mod m, then tn = t0 - that.
                    macc_reg <= addv_red[W-1:0];
                    my_reg   <= {my_reg[W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        t0_reg <= t1_reg;
                        t1_reg <= (t0_reg >= addv_red[W-1:0])
                            ? t0_reg - addv_red[W-1:0]
                            : m_reg - addv_red[W-1:0] + t0_reg;
                        cnt_reg <= CW'(W);
                        er_reg  <= '0;
                        q_reg   <= '0;
                        if (r1_reg == '0) begin
                            // r0 holds gcd; t1 (now t0) is the inverse.
                            if (r0_reg == W'(1)) begin
                                mx_reg <= a_reg; my_reg <= t1_reg; nx_reg <= NX_DONE;
                                macc_reg <= '0;
                                state_reg <= ST_MUL;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end else begin
                            state_reg <= ST_EUC;
                        end
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hdl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit: each transaction carries an opcode and four operands and yields
// one residue modulo the configured modulus plus a divide-by-zero flag. A front end takes
// transactions into a two-entry queue; a back-end sequencer reduces the four operands one
// bit per cycle, then works; a modulus below 2 or an unknown opcode just yields zero.
// Add, subtract and negate finish right after reduction; multiply takes one pass of the
// multiplier, multiply-accumulate two, exponentiation one or two per exponent bit, and
// divide one division and one multiply per Euclid step plus a final multiply, all on the
// shared shift-add modular multiplier. Results wait in the output register until taken.
// ----------------------------------------------------------------------------
// Modular arithmetic unit top level
// Front end, queue and iterative back end with the modulus register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module modular_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    input  logic [31:0] s_operand_c,
    input  logic [31:0] s_operand_d,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result,
    output logic        m_div_by_zero
);
    // The modulus register; only its low WORD_BITS bits take part.
    logic [31:0] modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= 32'd2;
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    logic           q_valid, q_ready;
    mau_pkg::item_t q_data;

    mau_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_operand_c (s_operand_c),
        .s_operand_d (s_operand_d),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data)
    );

    mau_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .modulus       (modulus_reg[WORD_BITS-1:0]),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_div_by_zero (m_div_by_zero)
    );

    // The flag only ever comes with a zero result.
    `ASSERT_CLK(a_flag_zero, aclk, aresetn, m_valid && m_div_by_zero |-> m_result == 32'd0, "flag with nonzero result")
    // A result stays in place while it is stalled.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_result), "result changed while stalled")
    // No result is shown in the cycle after reset.
    `ASSERT_ALWAYS(a_reset_idle, aclk, $past(!aresetn) |-> !m_valid, "result valid after reset")
endmodule
